// ===== rtl/cers_pkg.sv =====
// shared types, constants and codes for the crank edge rpm injection scheduler
// used by every module under rtl; no dependencies
package cers_pkg;

  localparam int unsigned TpmW      = 27;
  localparam int unsigned DivSteps  = TpmW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam logic [TpmW-1:0] TpmReset = TpmW'(75000000);
  localparam logic [15:0] RpmSat    = 16'hFFFF;
  localparam logic [31:0] HalfRange = 32'h8000_0000;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_MINUTE = 2'd0,
    CFG_MIN_PULSE_WIDTH  = 2'd1,
    CFG_MIN_ADVANCE      = 2'd2,
    CFG_SWITCH_OFF_TIME  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_HOLD  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT,
    ST_SUMS,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] edge_time;
    logic        pin_high;
    logic        overflow_pending;
    logic [15:0] timer_high;
    logic [31:0] cycle_period;
    logic [15:0] injection_angle;
    logic [15:0] pulse_width;
    logic        injector_running;
    logic [31:0] injector_end;
  } in_word_t;

  typedef struct packed {
    logic        leading_edge;
    logic [31:0] extended_time;
    logic [31:0] edge_period;
    logic [15:0] rpm;
    logic [1:0]  schedule_action;
    logic [15:0] start_time;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic calc_ext;
    logic calc_sums;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic lead;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cers_div.sv =====
// restoring divider, one quotient bit per cycle, for the speed quotient
// depends on cers_pkg
module cers_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cers_pkg::TpmW-1:0]     dividend_i,
  input  logic [31:0]                   divisor_i,
  output logic                          busy_o,
  output logic [cers_pkg::TpmW-1:0]     quotient_o
);

  logic                         busy_q, busy_d;
  logic [cers_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]                  rem_q, rem_d;
  logic [cers_pkg::TpmW-1:0]    quo_q, quo_d;
  logic [31:0]                  dvs_q, dvs_d;
  logic [32:0]                  rem_sh;
  logic [32:0]                  rem_sub;
  logic                         ge;
  logic                         last;

  assign rem_sh  = {rem_q, quo_q[cers_pkg::TpmW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign last    = cnt_q == cers_pkg::DivCntW'(cers_pkg::DivSteps - 1);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_d = {quo_q[cers_pkg::TpmW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && last && !start_i) |=> !busy_q) else $error("divider overran");

endmodule

// ===== rtl/cers_dp.sv =====
// datapath: config registers, timestamp extension, advance clamp, reschedule
// test, output register; depends on cers_pkg and cers_div
module cers_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cers_pkg::cmd_t                 cmd_i,
  output cers_pkg::sts_t                 sts_o,
  input  cers_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cers_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [cers_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cers_pkg::TpmW-1:0]      cfg_wdata_i
);

  logic [cers_pkg::TpmW-1:0] tpm_q;
  logic [15:0]               min_pw_q, min_adv_q, sot_q;
  cers_pkg::in_word_t        in_q;
  logic [31:0]               last_q, ext_q, period_q, sum_a_q, sum_b_q;
  logic [15:0]               adv_q;
  logic                      inj_en_q;
  logic                      out_valid_q;
  cers_pkg::out_word_t       out_q, out_d;

  logic [15:0]               hi;
  logic [31:0]               ext;
  logic [15:0]               max_after;
  logic [15:0]               adv;
  logic [31:0]               diff;
  logic [cers_pkg::TpmW-1:0] quo;
  logic                      div_busy;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q     <= cers_pkg::TpmReset;
      min_pw_q  <= '0;
      min_adv_q <= '0;
      sot_q     <= '0;
    end else if (cfg_we_i) begin
      case (cers_pkg::cfg_idx_e'(cfg_idx_i))
        cers_pkg::CFG_TICKS_PER_MINUTE: tpm_q     <= cfg_wdata_i;
        cers_pkg::CFG_MIN_PULSE_WIDTH:  min_pw_q  <= cfg_wdata_i[15:0];
        cers_pkg::CFG_MIN_ADVANCE:      min_adv_q <= cfg_wdata_i[15:0];
        cers_pkg::CFG_SWITCH_OFF_TIME:  sot_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // timestamp extension and advance clamp
  always_comb begin
    hi = in_q.timer_high;
    if (in_q.overflow_pending && !in_q.edge_time[15]) begin
      hi = in_q.timer_high + 16'd1;
    end
    ext       = {hi, in_q.edge_time};
    max_after = (|in_q.cycle_period[31:17]) ? 16'hFFFF : in_q.cycle_period[16:1];
    if (in_q.injection_angle > max_after) begin
      adv = max_after;
    end else if (in_q.injection_angle < min_adv_q) begin
      adv = min_adv_q;
    end else begin
      adv = in_q.injection_angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.calc_ext) begin
      last_q <= ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_word_i;
    end
    if (cmd_i.calc_ext) begin
      ext_q    <= ext;
      period_q <= ext - last_q;
      adv_q    <= adv;
      inj_en_q <= in_q.pulse_width > min_pw_q;
    end
    if (cmd_i.calc_sums) begin
      sum_a_q <= ext_q + {16'd0, adv_q};
      sum_b_q <= in_q.injector_end + {16'd0, sot_q};
    end
  end

  cers_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.calc_sums),
    .dividend_i (tpm_q),
    .divisor_i  (period_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // result word
  always_comb begin
    diff  = sum_a_q - sum_b_q;
    out_d = '0;
    if (in_q.pin_high) begin
      out_d.leading_edge  = 1'b1;
      out_d.extended_time = ext_q;
      out_d.edge_period   = period_q;
      out_d.rpm           = (|quo[cers_pkg::TpmW-1:16]) ? cers_pkg::RpmSat : quo[15:0];
      if (inj_en_q) begin
        out_d.start_time = in_q.edge_time + adv_q;
        if (!in_q.injector_running || (diff > cers_pkg::HalfRange)) begin
          out_d.schedule_action = cers_pkg::ACT_START;
        end else begin
          out_d.schedule_action = cers_pkg::ACT_HOLD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign sts_o.lead     = in_q.pin_high;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_word_o     = out_q;

  a_trailing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.leading_edge) |->
      (out_q.rpm == '0 && out_q.schedule_action == '0 && out_q.edge_period == '0))
    else $error("trailing word carries data");
  a_stamp_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.calc_ext |=> (last_q == ext_q)) else $error("edge stamp not updated");

endmodule

// ===== rtl/cers_ctrl.sv =====
// controller state machine sequencing capture, sums, division and output load
// depends on cers_pkg
module cers_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cers_pkg::sts_t sts_i,
  output cers_pkg::cmd_t cmd_o
);

  cers_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cers_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cers_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = cers_pkg::ST_EXT;
        end
      end
      cers_pkg::ST_EXT: begin
        if (sts_i.lead) begin
          cmd_o.calc_ext = 1'b1;
          state_d        = cers_pkg::ST_SUMS;
        end else begin
          state_d = cers_pkg::ST_DONE;
        end
      end
      cers_pkg::ST_SUMS: begin
        cmd_o.calc_sums = 1'b1;
        state_d         = cers_pkg::ST_DIV;
      end
      cers_pkg::ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = cers_pkg::ST_DONE;
        end
      end
      cers_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = cers_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cers_pkg::ST_IDLE;
      end
    endcase
  end

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cers_pkg::ST_SUMS) |=> sts_i.div_busy) else $error("divider did not start");
  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !sts_i.div_busy) else $error("result loaded mid division");

endmodule

// ===== rtl/crank_edge_rpm_injection_scheduler_top.sv =====
// Takes one crank edge word at a time. A trailing edge goes from extension to
// the done state; a leading edge runs the extension, sums and division states,
// the last on the one-bit-per-cycle speed divider; the next word is taken once
// the FSM is idle again, after the result enters the output register, which may
// hold a finished word while the following edge is worked on. Config writes belong
// in idle periods; depends on cers_pkg, cers_ctrl, cers_dp, cers_div
module crank_edge_rpm_injection_scheduler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cers_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cers_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [cers_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cers_pkg::TpmW-1:0]      cfg_wdata_i
);

  cers_pkg::cmd_t cmd;
  cers_pkg::sts_t sts;

  cers_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cers_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
